### hw/rtl/gif_lzw_code_packer_core_assert.svh
// Assertion macros for the GIF LZW code packer.
// Used by gif_lzw_code_packer_core; define NO_ASSERTIONS to compile them out.
`ifndef GIF_LZW_CODE_PACKER_CORE_ASSERT_SVH
`define GIF_LZW_CODE_PACKER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check a property on every edge, reset disabled.
`define GLCP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every edge, reset included.
`define GLCP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GLCP_ASSERT(label, clk, rst_n, prop, msg)
`define GLCP_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

### hw/rtl/glcp_pkg.sv
// Constants and types for the GIF LZW code packer.
// No dependencies; imported by gif_lzw_code_packer_core.
`timescale 1ns / 1ps
`default_nettype none

package glcp_pkg;

    localparam int MAX_CODE_BITS = 12;
    localparam int CODE_W        = MAX_CODE_BITS;
    localparam int WIDTH_W       = 4;
    localparam int DICT_AW       = MAX_CODE_BITS + 8;
    localparam int ACC_W         = 7 + MAX_CODE_BITS;
    localparam int CNT_W         = 5;
    localparam int MAX_PUSH      = 4;
    localparam int PUSH_W        = 3;
    localparam int PUSH_AW       = 2;
    localparam int FIFO_DEPTH    = 16;
    localparam int FIFO_AW       = 4;
    localparam int FIFO_CW       = 5;

    localparam logic [CODE_W-1:0]  CLR_CODE    = CODE_W'(256);
    localparam logic [CODE_W-1:0]  END_CODE    = CODE_W'(257);
    localparam logic [CODE_W-1:0]  FIRST_CODE  = CODE_W'(258);
    localparam logic [CODE_W-1:0]  FULL_CODE   = CODE_W'((1 << MAX_CODE_BITS) - 1);
    localparam logic [WIDTH_W-1:0] START_WIDTH = WIDTH_W'(9);
    localparam logic [WIDTH_W-1:0] MAX_WIDTH   = WIDTH_W'(MAX_CODE_BITS);
    localparam logic [FIFO_CW-1:0] FIFO_ROOM   = FIFO_CW'(FIFO_DEPTH - 2 * MAX_PUSH);

    typedef struct packed {
        logic [CODE_W-1:0]  code;
        logic [WIDTH_W-1:0] width;
        logic               end_mark;
    } code_entry_t;

endpackage

`default_nettype wire

### hw/rtl/gif_lzw_code_packer_core.sv
// GIF LZW compressor with LSB-first code packer: dictionary, check table, code queue.
// Depends on glcp_pkg and gif_lzw_code_packer_core_assert.svh.
//
// Usage: pixels enter on the pixel channel (pixel_valid/pixel_ready, pixel_index,
// last_pixel); packed bytes leave on the byte channel (byte_valid/byte_ready,
// out_byte, last_byte). The first pixel after reset or after a last_pixel starts
// a frame with a Clear code; last_pixel closes it with the prefix, EOI and a
// flush of the partial byte, and last_byte marks the frame's final byte.
// A new pixel is taken only once the last one has left the first lookup stage;
// the dictionary loop is a 1M-entry prefix/symbol RAM read, a 4K-entry check RAM
// read at the returned code, then the write of a new code in the cycle the next
// pixel is accepted. Bytes leave at up to one per cycle while byte_ready allows.
// Codes of a pixel enter the code queue from the s2 lookup stage; bytes follow.
// Reset: control state returns to its start values at once. No clearing pass
// is run: a dictionary entry counts only if its code lies in the live range and
// the check RAM maps that code back to the same entry, so stale RAM is ignored.
// Stall: a held byte_ready backs up the code queue; pixel_ready drops when the
// queue cannot take the codes of another pixel, and nothing is lost.
`timescale 1ns / 1ps
`default_nettype none
`include "gif_lzw_code_packer_core_assert.svh"

module gif_lzw_code_packer_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       pixel_valid,
    output logic            pixel_ready,
    input  wire logic [7:0] pixel_index,
    input  wire logic       last_pixel,
    output logic            byte_valid,
    input  wire logic       byte_ready,
    output logic [7:0]      out_byte,
    output logic            last_byte
);
    import glcp_pkg::*;

    // dictionary and check memories
    logic [CODE_W-1:0]  dict_mem [1 << DICT_AW];
    logic [DICT_AW-1:0] rev_mem  [1 << CODE_W];
    logic [CODE_W-1:0]  dict_q;
    logic [DICT_AW-1:0] rev_q;

    // lookup pipeline
    logic               s1_valid_reg;
    logic               s2_valid_reg;
    logic [7:0]         pix_reg;
    logic               last_reg;
    logic [DICT_AW-1:0] idx_reg;
    logic [CODE_W-1:0]  c2_reg;
    logic               fwd_reg;
    logic [CODE_W-1:0]  fwd_code_reg;

    // compressor state
    logic               in_frame_reg, in_frame_next;
    logic [CODE_W-1:0]  prefix_reg, prefix_next;
    logic [CODE_W-1:0]  last_code_reg, last_code_next;
    logic [WIDTH_W-1:0] width_reg, width_next;

    // code queue
    code_entry_t        fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CW-1:0] fifo_count_reg;
    code_entry_t        push_ent [MAX_PUSH];
    logic [PUSH_W-1:0]  push_cnt;
    code_entry_t        head;

    // packer
    logic [ACC_W-1:0]   acc_reg, acc_next, acc_a;
    logic [CNT_W-1:0]   cnt_reg, cnt_next, cnt_a;
    logic               end_pending_reg, end_pending_next, end_a;
    logic               byte_valid_reg;
    logic [7:0]         out_byte_reg;
    logic               last_byte_reg;

    logic               accept;
    logic [DICT_AW-1:0] rd_addr;
    logic [CODE_W-1:0]  dict_eff;
    logic               hit;
    logic [CODE_W-1:0]  la_inc;
    logic               grow;
    logic [WIDTH_W-1:0] w_grown;
    logic               dict_we;
    logic               out_free, emit_full, emit_flush, emit, emit_last, pop;

    assign pixel_ready = !s1_valid_reg && (fifo_count_reg <= FIFO_ROOM);
    assign accept      = pixel_valid && pixel_ready;
    assign dict_eff    = fwd_reg ? fwd_code_reg : dict_q;
    assign rd_addr     = {prefix_next, pixel_index};
    assign head        = fifo_mem[rd_ptr_reg];

    // hit needs a live code whose check entry points back at this slot
    assign hit = in_frame_reg && (c2_reg >= FIRST_CODE) && (c2_reg <= last_code_reg)
                 && (rev_q == idx_reg);
    assign la_inc  = last_code_reg + CODE_W'(1);
    assign grow    = ({1'b0, la_inc} >= ((CODE_W + 1)'(1) << width_reg))
                     && (width_reg < MAX_WIDTH);
    assign w_grown = grow ? width_reg + WIDTH_W'(1) : width_reg;

    always_comb
    begin
        prefix_next    = prefix_reg;
        last_code_next = last_code_reg;
        width_next     = width_reg;
        in_frame_next  = in_frame_reg;
        dict_we        = 1'b0;
        push_cnt       = '0;
        for (int k = 0; k < MAX_PUSH; k++)
        begin
            push_ent[k] = '0;
        end
        if (s2_valid_reg)
        begin
            priority if (!in_frame_reg)
            begin
                push_ent[push_cnt[PUSH_AW-1:0]] =
                    '{code: CLR_CODE, width: START_WIDTH, end_mark: 1'b0};
                push_cnt           = push_cnt + PUSH_W'(1);
                last_code_next     = END_CODE;
                width_next         = START_WIDTH;
                prefix_next        = {{(CODE_W - 8){1'b0}}, pix_reg};
                in_frame_next      = 1'b1;
            end
            else if (hit)
            begin
                prefix_next = c2_reg;
            end
            else
            begin
                push_ent[push_cnt[PUSH_AW-1:0]] =
                    '{code: prefix_reg, width: width_reg, end_mark: 1'b0};
                push_cnt           = push_cnt + PUSH_W'(1);
                dict_we            = 1'b1;
                if (la_inc == FULL_CODE)
                begin
                    push_ent[push_cnt[PUSH_AW-1:0]] =
                        '{code: CLR_CODE, width: w_grown, end_mark: 1'b0};
                    push_cnt           = push_cnt + PUSH_W'(1);
                    last_code_next     = END_CODE;
                    width_next         = START_WIDTH;
                end
                else
                begin
                    last_code_next = la_inc;
                    width_next     = w_grown;
                end
                prefix_next = {{(CODE_W - 8){1'b0}}, pix_reg};
            end
            if (last_reg)
            begin
                push_ent[push_cnt[PUSH_AW-1:0]] =
                    '{code: prefix_next, width: width_next, end_mark: 1'b0};
                push_cnt           = push_cnt + PUSH_W'(1);
                push_ent[push_cnt[PUSH_AW-1:0]] =
                    '{code: END_CODE, width: width_next, end_mark: 1'b1};
                push_cnt           = push_cnt + PUSH_W'(1);
                in_frame_next      = 1'b0;
            end
        end
    end

    // packer: emit a byte, then absorb the head code into the free bits above the held ones
    always_comb
    begin
        out_free   = !byte_valid_reg || byte_ready;
        emit_full  = out_free && (cnt_reg >= CNT_W'(8));
        emit_flush = out_free && (cnt_reg < CNT_W'(8)) && end_pending_reg;
        emit       = emit_full || emit_flush;
        emit_last  = (emit_full && end_pending_reg && (cnt_reg == CNT_W'(8))) || emit_flush;
        priority if (emit_full)
        begin
            acc_a = acc_reg >> 8;
            cnt_a = cnt_reg - CNT_W'(8);
        end
        else if (emit_flush)
        begin
            acc_a = '0;
            cnt_a = '0;
        end
        else
        begin
            acc_a = acc_reg;
            cnt_a = cnt_reg;
        end
        end_a = end_pending_reg && !emit_last;
        pop   = (fifo_count_reg != '0) && (cnt_a < CNT_W'(8)) && !end_a;
        if (pop)
        begin
            acc_next         = acc_a | (ACC_W'(head.code) << cnt_a);
            cnt_next         = cnt_a + CNT_W'(head.width);
            end_pending_next = end_a || head.end_mark;
        end
        else
        begin
            acc_next         = acc_a;
            cnt_next         = cnt_a;
            end_pending_next = end_a;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dict_we)
        begin
            dict_mem[idx_reg] <= la_inc;
        end
        if (accept)
        begin
            dict_q <= dict_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dict_we)
        begin
            rev_mem[la_inc] <= idx_reg;
        end
        if (s1_valid_reg)
        begin
            rev_q <= rev_mem[dict_eff];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_PUSH; k++)
        begin
            if (PUSH_W'(k) < push_cnt)
            begin
                fifo_mem[wr_ptr_reg + FIFO_AW'(k)] <= push_ent[k];
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_reg      <= pixel_index;
            last_reg     <= last_pixel;
            idx_reg      <= rd_addr;
            fwd_code_reg <= la_inc;
        end
        if (s1_valid_reg)
        begin
            c2_reg <= dict_eff;
        end
        if (emit)
        begin
            out_byte_reg  <= acc_reg[7:0];
            last_byte_reg <= emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            fwd_reg         <= 1'b0;
            in_frame_reg    <= 1'b0;
            prefix_reg      <= '0;
            last_code_reg   <= END_CODE;
            width_reg       <= START_WIDTH;
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            fifo_count_reg  <= '0;
            acc_reg         <= '0;
            cnt_reg         <= '0;
            end_pending_reg <= 1'b0;
            byte_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            // forward a write that lands on the slot being read at the same edge
            if (accept)
            begin
                fwd_reg <= dict_we && (idx_reg == rd_addr);
            end
            in_frame_reg    <= in_frame_next;
            prefix_reg      <= prefix_next;
            last_code_reg   <= last_code_next;
            width_reg       <= width_next;
            wr_ptr_reg      <= wr_ptr_reg + FIFO_AW'(push_cnt);
            rd_ptr_reg      <= rd_ptr_reg + FIFO_AW'(pop);
            fifo_count_reg  <= fifo_count_reg + FIFO_CW'(push_cnt) - FIFO_CW'(pop);
            acc_reg         <= acc_next;
            cnt_reg         <= cnt_next;
            end_pending_reg <= end_pending_next;
            priority if (emit)
            begin
                byte_valid_reg <= 1'b1;
            end
            else if (byte_ready)
            begin
                byte_valid_reg <= 1'b0;
            end
        end
    end

    assign byte_valid = byte_valid_reg;
    assign out_byte   = out_byte_reg;
    assign last_byte  = last_byte_reg;

    `GLCP_ASSERT_ALWAYS(a_one_stage, clk, !(s1_valid_reg && s2_valid_reg), "two pixels in lookup")
    `GLCP_ASSERT(a_s1_to_s2, clk, rst_n, s1_valid_reg |=> s2_valid_reg, "lookup stage lost")
    `GLCP_ASSERT(a_queue_bound, clk, rst_n, fifo_count_reg <= FIFO_CW'(FIFO_DEPTH),
                 "code queue overflow")
    `GLCP_ASSERT(a_width_range, clk, rst_n,
                 (width_reg >= START_WIDTH) && (width_reg <= MAX_WIDTH), "code width out of range")
    `GLCP_ASSERT(a_cnt_bound, clk, rst_n, cnt_reg <= CNT_W'(ACC_W), "bit count overflow")

endmodule

`default_nettype wire

### test/testbench.sv
// Self-checking bench for gif_lzw_code_packer_core: feeds palette frames, predicts the
// packed LZW byte stream and checks every byte. Depends on glcp_pkg and the core RTL.
`timescale 1ns / 1ps

module testbench;
    import glcp_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_PIXELS = 60;
    localparam int LONG_FRAME = 280;

    typedef struct {
        logic [7:0] pix;
        logic       fin;
    } pixel_word_t;

    typedef struct {
        logic [7:0] data;
        logic       fin;
    } stream_byte_t;

    typedef enum int {FRAME_WIDE, FRAME_NARROW, FRAME_RUNS} frame_kind_t;
    typedef enum int {RX_OPEN, RX_COIN, RX_TRICKLE} rx_mode_t;

    logic       clk;
    logic       rst_n;
    logic       pixel_valid;
    logic       pixel_ready;
    logic [7:0] pixel_index;
    logic       last_pixel;
    logic       byte_valid;
    logic       byte_ready;
    logic [7:0] out_byte;
    logic       last_byte;

    gif_lzw_code_packer_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel_index (pixel_index),
        .last_pixel  (last_pixel),
        .byte_valid  (byte_valid),
        .byte_ready  (byte_ready),
        .out_byte    (out_byte),
        .last_byte   (last_byte)
    );

    pixel_word_t  pending_pixels[$];
    stream_byte_t expected_bytes[$];
    int           items_total = 0;
    int           pixels_in = 0;
    int           bytes_out = 0;
    int           errors = 0;
    int           cycles = 0;
    logic         pixel_took = 1'b0;

    // encoder image: string table, prefix, code counter, width and bit packer
    logic [11:0]  string_table [int unsigned];
    logic [11:0]  prefix = '0;
    logic [11:0]  last_code = END_CODE;
    logic [3:0]   code_width = START_WIDTH;
    logic [6:0]   bit_acc = '0;
    logic [2:0]   bit_cnt = '0;
    logic         in_frame = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic flag_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        errors++;
    endtask

    task automatic pack_code(input logic [11:0] code);
        logic [31:0] bits;
        int          nbits;
        bits = 32'(bit_acc) | (32'(code) << bit_cnt);
        nbits = int'(bit_cnt) + int'(code_width);
        while (nbits >= 8)
        begin
            expected_bytes.insert(expected_bytes.size(), '{data: bits[7:0], fin: 1'b0});
            bits = bits >> 8;
            nbits -= 8;
        end
        bit_acc = bits[6:0];
        bit_cnt = 3'(nbits);
    endtask

    task automatic lzw_encode_pixel(input logic [7:0] pix, input logic fin);
        int unsigned key;
        key = {prefix, pix};
        if (!in_frame)
        begin
            string_table.delete();
            last_code = END_CODE;
            code_width = START_WIDTH;
            pack_code(CLR_CODE);
            prefix = {4'b0, pix};
            in_frame = 1'b1;
        end
        else if (string_table.exists(key))
        begin
            prefix = string_table[key];
        end
        else
        begin
            pack_code(prefix);
            last_code = last_code + 12'd1;
            string_table[key] = last_code;
            if (int'(last_code) >= (1 << code_width) && code_width < MAX_WIDTH)
                code_width = code_width + 4'd1;
            // table full: Clear at the grown width, then start over
            if (last_code == FULL_CODE)
            begin
                pack_code(CLR_CODE);
                string_table.delete();
                last_code = END_CODE;
                code_width = START_WIDTH;
            end
            prefix = {4'b0, pix};
        end
        if (fin)
        begin
            pack_code(prefix);
            pack_code(END_CODE);
            if (bit_cnt != 0)
                expected_bytes.insert(expected_bytes.size(),
                                      '{data: {1'b0, bit_acc}, fin: 1'b0});
            expected_bytes[$].fin = 1'b1;
            bit_acc = '0;
            bit_cnt = '0;
            in_frame = 1'b0;
        end
    endtask

    task automatic add_pixel(input logic [7:0] pix, input logic fin);
        pending_pixels.insert(pending_pixels.size(), '{pix: pix, fin: fin});
    endtask

    task automatic queue_frame(input int len, input frame_kind_t kind);
        logic [7:0] base;
        logic [7:0] cur;
        base = 8'($urandom_range(0, 255));
        cur = base;
        for (int k = 0; k < len; k++)
        begin
            case (kind)
                FRAME_WIDE:   cur = 8'($urandom_range(0, 255));
                FRAME_NARROW: cur = base + 8'($urandom_range(0, 3));
                default:      if ($urandom_range(0, 3) == 0) cur = 8'($urandom_range(0, 255));
            endcase
            add_pixel(cur, k == len - 1);
        end
    endtask

    // sender: bursts of random length with random gaps, word held until taken
    int burst_left = 1;
    int gap_left = 0;

    always @(negedge clk)
    begin
        pixel_word_t w;
        if (pixel_valid && !pixel_took)
        begin
            // hold the word
        end
        else if (gap_left > 0)
        begin
            gap_left--;
            pixel_valid <= 1'b0;
        end
        else if (pending_pixels.size() > 0)
        begin
            w = pending_pixels.pop_front();
            pixel_valid <= 1'b1;
            pixel_index <= w.pix;
            last_pixel <= w.fin;
            if (burst_left > 1)
                burst_left--;
            else if ($urandom_range(0, 7) == 0)
            begin
                burst_left = 200;
                gap_left = 0;
            end
            else
            begin
                burst_left = $urandom_range(1, 24);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
        end
        else
        begin
            pixel_valid <= 1'b0;
        end
    end

    // receiver: stall pattern of its own, plus long hold-offs to back up the core
    rx_mode_t rx_mode = RX_OPEN;
    int       mode_left = 0;
    int       trickle_phase = 0;
    int       hold_left = 0;
    int       next_hold_at = 100;

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            byte_ready <= 1'b0;
        end
        else if (pixels_in >= next_hold_at)
        begin
            hold_left = HOLD_CYCLES;
            next_hold_at = (next_hold_at == 100) ? 300 : 32'h7fffffff;
            byte_ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 2));
                mode_left = $urandom_range(32, 256);
            end
            else
            begin
                mode_left--;
            end
            trickle_phase = (trickle_phase + 1) % 4;
            case (rx_mode)
                RX_OPEN:  byte_ready <= 1'b1;
                RX_COIN:  byte_ready <= 1'($urandom_range(0, 1));
                default:  byte_ready <= (trickle_phase == 0);
            endcase
        end
    end

    // predict on every accepted pixel, then check every accepted byte
    always @(posedge clk)
    begin
        stream_byte_t want;
        pixel_took <= rst_n && pixel_valid && pixel_ready;
        if (rst_n && pixel_valid && pixel_ready)
        begin
            lzw_encode_pixel(pixel_index, last_pixel);
            pixels_in <= pixels_in + 1;
        end
        if (rst_n && byte_valid && byte_ready)
        begin
            if (expected_bytes.size() == 0)
            begin
                flag_mismatch($sformatf("byte %0d: 0x%02h with nothing expected",
                                        bytes_out, out_byte));
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (out_byte !== want.data)
                    flag_mismatch($sformatf("byte %0d: out_byte 0x%02h, want 0x%02h",
                                            bytes_out, out_byte, want.data));
                if (last_byte !== want.fin)
                    flag_mismatch($sformatf("byte %0d: last_byte %0b, want %0b",
                                            bytes_out, last_byte, want.fin));
            end
            bytes_out <= bytes_out + 1;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("[gif_lzw_code_packer_core] ERROR");
            $finish;
        end
    end

    initial
    begin
        int random_left;
        int len;
        bit long_done;
        rst_n = 1'b0;
        pixel_valid = 1'b0;
        pixel_index = '0;
        last_pixel = 1'b0;
        byte_ready = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(posedge clk);

        // single-pixel frames at both ends of the palette
        add_pixel(8'h00, 1'b1);
        add_pixel(8'hFF, 1'b1);
        // alternating pair: table hits on repeated strings
        add_pixel(8'hAA, 1'b0);
        add_pixel(8'h55, 1'b0);
        add_pixel(8'hAA, 1'b0);
        add_pixel(8'h55, 1'b0);
        add_pixel(8'hAA, 1'b0);
        add_pixel(8'h55, 1'b1);
        // a run of one value: string grows onto itself
        for (int k = 0; k < 7; k++)
            add_pixel(8'h07, k == 6);
        add_pixel(8'h00, 1'b0);
        add_pixel(8'hFF, 1'b1);
        add_pixel(8'h80, 1'b0);
        add_pixel(8'h01, 1'b1);

        random_left = RANDOM_PIXELS;
        long_done = 1'b0;
        while (random_left > 0)
        begin
            len = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 40);
            if (len > random_left)
                len = random_left;
            queue_frame(len, frame_kind_t'($urandom_range(0, 2)));
            random_left -= len;
            // one frame long enough to assign past code 511 and grow the width
            if (!long_done && random_left < 200)
            begin
                queue_frame(LONG_FRAME, FRAME_WIDE);
                long_done = 1'b1;
            end
        end
        items_total = pending_pixels.size();

        while (pixels_in < items_total || expected_bytes.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (expected_bytes.size() != 0)
            flag_mismatch($sformatf("%0d bytes never arrived", expected_bytes.size()));

        if (errors == 0)
            $display("[gif_lzw_code_packer_core] OK");
        else
            $display("[gif_lzw_code_packer_core] ERROR");
        $finish;
    end

endmodule
